// ===== hw/rtl/ichc_pkg.sv =====
package ichc_pkg;

    // FNV-1a 64-bit constants.
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic mix;
        logic fold;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_status;

    // Multiplication by the FNV prime modulo 2^64.
    // The prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        fnv_mul = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

    // Zero is replaced by one so that a hash is never empty.
    function automatic logic [63:0] nonzero(input logic [63:0] x);
        nonzero = (x == 64'd0) ? 64'd1 : x;
    endfunction

endpackage

// ===== hw/rtl/ichc_ctrl.sv =====
module ichc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_byte,
    input  ichc_pkg::t_status i_status,
    output ichc_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);
    import ichc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a last byte sends the controller to fold the image hash.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_last_byte) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: bytes are taken in idle; the fold waits for a free output register.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.mix = i_in_valid;
            end
            ST_FOLD: begin
                o_in_stall = 1'b1;
                o_cmd.fold = i_status.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/ichc_datapath.sv =====
module ichc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ichc_pkg::t_cmd    i_cmd,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_image,
    input  logic              i_out_stall,
    output ichc_pkg::t_status o_status,
    output logic              o_out_valid,
    output logic [63:0]       o_image_hash,
    output logic [63:0]       o_sequence_hash
);
    import ichc_pkg::*;

    logic [63:0] r_acc;
    logic [63:0] r_run;
    logic        r_first;
    logic        r_out_valid;
    logic [63:0] r_image_hash;
    logic [63:0] r_sequence_hash;
    logic [63:0] n_image_hash;
    logic [63:0] n_run;

    // Image finalisation and folding into the running sequence hash.
    always_comb begin
        n_image_hash = nonzero(r_acc);
        if ((r_run == 64'd0) || r_first) begin
            n_run = n_image_hash;
        end else begin
            n_run = nonzero(fnv_mul(r_run) ^ n_image_hash);
        end
    end

    // Accumulator, running hash and the first-image flag of the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= FNV_BASIS;
            r_run <= 64'd0;
        end else if (i_cmd.fold) begin
            r_acc <= FNV_BASIS;
            r_run <= n_run;
        end else if (i_cmd.mix) begin
            r_acc <= fnv_mul(r_acc ^ {56'd0, i_data_byte});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_first <= i_first_image;
        end
    end

    // Output register: loaded by a fold, emptied when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fold) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fold) begin
            r_image_hash    <= n_image_hash;
            r_sequence_hash <= n_run;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_image_hash      = r_image_hash;
    assign o_sequence_hash   = r_sequence_hash;

endmodule

// ===== hw/rtl/image_content_hash_chain_unit.sv =====
// Image content hash chain: 64-bit FNV-1a over the bytes of a run of images.
// The input channel carries one byte per transaction with a last-byte flag
// and a first-image flag, of which the last byte's value is used. Each
// byte is mixed into the accumulator in the cycle it is accepted, so bytes
// of an image stream in at one per cycle.
// On the last byte the controller moves to the fold state, folding the
// image hash into the running sequence hash; the input is stalled during
// the fold. The result transaction (image hash and sequence hash) becomes
// valid when the fold loads the output register, which it does as soon as
// that register is free. The fold's logic depth is set by the constant
// prime multiply (a shift-add tree) on the running hash.
// The result sits in an output register; further bytes are accepted while
// it waits. If the receiver stalls, the next image's fold is held in the
// fold state until the output register is free.
// Reset (synchronous, active low) returns the accumulator to the offset
// basis, empties the running hash and clears the output register.
module image_content_hash_chain_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_first_image,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_image_hash,
    output logic [63:0] o_sequence_hash
);
    import ichc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller.
    ichc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    // Datapath.
    ichc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_data_byte     (i_data_byte),
        .i_first_image   (i_first_image),
        .i_out_stall     (i_out_stall),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_image_hash    (o_image_hash),
        .o_sequence_hash (o_sequence_hash)
    );

endmodule
